// File: src/byte_fat_chain_engine_macros.svh
// Assertion macros used by the checker file of the allocation table engine.
`ifndef BYTE_FAT_CHAIN_ENGINE_MACROS_SVH
`define BYTE_FAT_CHAIN_ENGINE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define BFCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define BFCE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bfce_pkg.sv
// Shared constants, types and helper functions of the allocation table engine.
`timescale 1ns / 1ps
package bfce_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAX_RESULTS   = 64;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0]       TABLE_END    = 8'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] RESULT_LIMIT = CNT_W'(MAX_RESULTS);

  localparam logic [7:0] OUT_OF_TABLE = 8'h8f;
  localparam logic [7:0] TERM_LO      = 8'h80;
  localparam logic [7:0] NO_TERMINAL  = 8'hff;
  localparam logic [7:0] SECTOR_BIAS  = 8'h7f;

  // Register byte addresses on the configuration port
  localparam logic [2:0] REG_FIRST_ADDR = 3'd0;
  localparam logic [2:0] REG_COUNT_ADDR = 3'd4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_WALK  = 2'd2,
    OP_LINK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {WR_NONE, WR_IN, WR_PREV, WR_ITEM} wr_sel_t;
  typedef enum logic [1:0] {RD_NONE, RD_IN, RD_CUR} rd_sel_t;
  typedef enum logic [1:0] {EM_NONE, EM_READ, EM_MEMBER, EM_FINAL} emit_t;

  typedef struct packed {
    logic    load;
    logic    link_upd;
    logic    step;
    logic    next_step;
    wr_sel_t wr;
    rd_sel_t rd;
    emit_t   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic member;
    logic terminal;
    logic out_free;
    logic link_pending;
  } dp_stat_t;

  function automatic logic is_terminal(input logic [7:0] v);
    is_terminal = (v[7:4] == TERM_LO[7:4]) || (v == NO_TERMINAL);
  endfunction

  function automatic logic [4:0] sectors_of(input logic [7:0] flag);
    logic [7:0] diff;
    diff = flag - SECTOR_BIAS;
    if (flag[7:4] == TERM_LO[7:4]) begin
      sectors_of = diff[4:0];
    end else begin
      sectors_of = 5'd0;
    end
  endfunction

endpackage

// File: src/byte_fat_chain_engine.sv
// Top level of the byte-per-cluster allocation table engine.
// Usage: items arrive on the in_ stream; in_tuser is the operation (write,
// read, walk, link), in_tdata carries cluster and value, in_tlast marks the
// final cluster of a link run. Results leave on the out_ stream; out_tlast
// marks the last result of an item and out_tuser says the data is a chain
// member. Registers first_usable_cluster (0x0) and cluster_count (0x4) sit
// on the APB-style cfg_ port; write them only while the block is idle.
// One item at a time. A write or link is handled when the item is taken;
// a link adds a second write (the terminal flag) when it closes a run that
// had a pending element. A read result passes the table read register, then
// the output register. A walk takes one table read and one decision on the
// returned entry per chain cluster, up to 64; the table read port paces it.
// Reset: the table reads as all zero at once through per-entry valid bits;
// no clearing pass, the block takes items from the first cycle after reset.
// Stall: a result waits in the output register; the next item can already
// be taken, and a read or a walk pauses while the register is still full.
`timescale 1ns / 1ps
module byte_fat_chain_engine import bfce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] cluster, [15:8] value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic        in_tlast,   // last
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data, [15:8] end_flag, [20:16] used_sectors, pad
  output logic        out_tuser,  // [0] in_chain
  output logic        out_tlast,  // final_res
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0] first_r, count_r;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] res_data, res_flag;
  logic [4:0] res_used;

  // Register file: the word address bit picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 7'd2;
      count_r <= 7'd64;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_COUNT_ADDR[2]) begin
        count_r <= cfg_pwdata[6:0];
      end else begin
        first_r <= cfg_pwdata[6:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FIRST_ADDR[2]) ? {25'd0, first_r}
                                                          : {25'd0, count_r};

  bfce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (op_t'(in_tuser)),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfce_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_cluster    (in_tdata[7:0]),
    .in_value      (in_tdata[15:8]),
    .in_last       (in_tlast),
    .first_usable  (first_r),
    .cluster_count (count_r),
    .stat          (stat),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_data      (res_data),
    .out_in_chain  (out_tuser),
    .out_final     (out_tlast),
    .out_end_flag  (res_flag),
    .out_used      (res_used)
  );

  assign out_tdata = {3'd0, res_used, res_flag, res_data};

endmodule

// File: src/bfce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: src/bfce_ctrl.sv
// Sequencer for write, read, walk and link items.
`timescale 1ns / 1ps
module bfce_ctrl import bfce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  op_t      in_op,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LINK, S_CHECK, S_NEXT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.link_upd  = 1'b0;
    cmd.step      = 1'b0;
    cmd.next_step = 1'b0;
    cmd.wr        = WR_NONE;
    cmd.rd        = RD_NONE;
    cmd.emit      = EM_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_WRITE: cmd.wr = WR_IN;
            OP_READ: begin
              cmd.rd    = RD_IN;
              state_nxt = S_READ;
            end
            OP_WALK: state_nxt = S_CHECK;
            OP_LINK: begin
              cmd.link_upd = 1'b1;
              if (stat.link_pending) begin
                cmd.wr = WR_PREV;
                // second write (terminal flag) needs the port next cycle
                if (in_last) begin
                  state_nxt = S_LINK;
                end
              end else if (in_last) begin
                cmd.wr = WR_IN;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LINK: begin
        cmd.wr    = WR_ITEM;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.emit  = EM_READ;
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!stat.member) begin
          state_nxt = S_FINISH;
        end else if (stat.out_free) begin
          cmd.rd    = RD_CUR;
          cmd.step  = 1'b1;
          cmd.emit  = EM_MEMBER;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.next_step = 1'b1;
        state_nxt     = stat.terminal ? S_FINISH : S_CHECK;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = EM_FINAL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/bfce_dp.sv
// Datapath: allocation table, valid and visited bits, walk registers, result register.
`timescale 1ns / 1ps
module bfce_dp import bfce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_cluster,
  input  logic [7:0]  in_value,
  input  logic        in_last,
  input  logic [6:0]  first_usable,
  input  logic [6:0]  cluster_count,
  output dp_stat_t    stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_data,
  output logic        out_in_chain,
  output logic        out_final,
  output logic [7:0]  out_end_flag,
  output logic [4:0]  out_used
);

  logic [7:0]         item_cl_r, item_val_r;
  logic [7:0]         link_prev_r;
  logic               link_pend_r;
  logic [7:0]         cur_r, pend_r, flag_r;
  logic               pend_vld_r;
  logic [CNT_W-1:0]   n_r;
  logic [TABLE_ENTRIES-1:0] seen_r, valid_r;
  logic               rd_oot_r, rd_vld_r;
  logic [7:0]         ram_q;

  logic [7:0]       wr_addr, wr_data, rd_addr, entry;
  logic             ram_we, ram_re;
  logic             cur_in_table, cur_seen;
  logic             emit_fire;
  logic [7:0]       em_data, em_flag;
  logic             em_chain, em_last;
  logic [4:0]       em_used;

  logic             out_valid_r, out_chain_r, out_last_r;
  logic [7:0]       out_data_r, out_flag_r;
  logic [4:0]       out_used_r;

  // Write port selection
  always_comb begin
    case (cmd.wr)
      WR_IN: begin
        wr_addr = in_cluster;
        wr_data = in_value;
      end
      WR_PREV: begin
        wr_addr = link_prev_r;
        wr_data = in_cluster;
      end
      WR_ITEM: begin
        wr_addr = item_cl_r;
        wr_data = item_val_r;
      end
      default: begin
        wr_addr = 8'd0;
        wr_data = 8'd0;
      end
    endcase
  end
  assign ram_we = (cmd.wr != WR_NONE) && (wr_addr < TABLE_END);

  assign rd_addr = (cmd.rd == RD_CUR) ? cur_r : in_cluster;
  assign ram_re  = (cmd.rd != RD_NONE);

  bfce_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (ram_re),
    .rd_addr (rd_addr[IDX_W-1:0]),
    .rd_data (ram_q)
  );

  // Never-written entries read as zero; beyond the table reads as terminal.
  assign entry = rd_oot_r ? OUT_OF_TABLE : (rd_vld_r ? ram_q : 8'd0);

  assign cur_in_table = (cur_r < TABLE_END);
  assign cur_seen     = cur_in_table && seen_r[cur_r[IDX_W-1:0]];

  assign stat.member = (cur_r >= {1'b0, first_usable}) &&
                       (cur_r < {1'b0, cluster_count}) &&
                       !cur_seen && (n_r < RESULT_LIMIT);
  assign stat.terminal     = is_terminal(entry);
  assign stat.out_free     = !out_valid_r || out_ready;
  assign stat.link_pending = link_pend_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      seen_r      <= '0;
      link_pend_r <= 1'b0;
      link_prev_r <= 8'd0;
      pend_vld_r  <= 1'b0;
      n_r         <= '0;
    end else begin
      if (ram_we) begin
        valid_r[wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.load) begin
        seen_r     <= '0;
        pend_vld_r <= 1'b0;
        n_r        <= '0;
      end
      if (cmd.step) begin
        if (cur_in_table) begin
          seen_r[cur_r[IDX_W-1:0]] <= 1'b1;
        end
        pend_vld_r <= 1'b1;
        n_r        <= n_r + 1'b1;
      end
      if (cmd.link_upd) begin
        if (in_last) begin
          link_pend_r <= 1'b0;
        end else begin
          link_pend_r <= 1'b1;
          link_prev_r <= in_cluster;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cl_r  <= in_cluster;
      item_val_r <= in_value;
      cur_r      <= in_cluster;
      flag_r     <= NO_TERMINAL;
    end
    if (ram_re) begin
      rd_oot_r <= (rd_addr >= TABLE_END);
      rd_vld_r <= valid_r[rd_addr[IDX_W-1:0]];
    end
    if (cmd.step) begin
      pend_r <= cur_r;
    end
    if (cmd.next_step) begin
      if (is_terminal(entry)) begin
        flag_r <= entry;
      end else begin
        cur_r <= entry;
      end
    end
  end

  // Result formation; a member is sent one step late so the final mark can follow
  always_comb begin
    emit_fire = 1'b0;
    em_data   = 8'd0;
    em_chain  = 1'b0;
    em_last   = 1'b0;
    em_flag   = 8'd0;
    em_used   = 5'd0;
    case (cmd.emit)
      EM_READ: begin
        emit_fire = 1'b1;
        em_data   = entry;
        em_last   = 1'b1;
      end
      EM_MEMBER: begin
        emit_fire = pend_vld_r;
        em_data   = pend_r;
        em_chain  = 1'b1;
      end
      EM_FINAL: begin
        emit_fire = 1'b1;
        em_data   = pend_vld_r ? pend_r : 8'd0;
        em_chain  = pend_vld_r;
        em_last   = 1'b1;
        em_flag   = flag_r;
        em_used   = sectors_of(flag_r);
      end
      default: emit_fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r  <= em_data;
      out_chain_r <= em_chain;
      out_last_r  <= em_last;
      out_flag_r  <= em_flag;
      out_used_r  <= em_used;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_in_chain = out_chain_r;
  assign out_final    = out_last_r;
  assign out_end_flag = out_flag_r;
  assign out_used     = out_used_r;

endmodule

// File: src/bfce_checker.sv
// Port-level checks of the allocation table engine, bound to the top level.
`timescale 1ns / 1ps
`include "byte_fat_chain_engine_macros.svh"
module bfce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  `BFCE_ASSERT_RST(a_rst_no_result, !rst_n |=> !out_tvalid, "result valid after reset")
  `BFCE_ASSERT(a_hold_stalled, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `BFCE_ASSERT(a_nonmember_final, out_tvalid && !out_tuser |-> out_tlast, "non-member result not final")
  `BFCE_ASSERT(a_midchain_clean, out_tvalid && !out_tlast |-> out_tdata[20:8] == 13'd0, "end flag on a middle result")
  `BFCE_ASSERT(a_sectors_flag, out_tvalid && out_tdata[20:16] != 5'd0 |-> out_tdata[15:12] == 4'h8, "sector count without terminal flag")

endmodule

bind byte_fat_chain_engine bfce_checker u_bfce_checker (.*);
